// File: hdl/upd_pkg.sv
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character codes and helpers for the URL percent decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package upd_pkg;

  localparam logic [7:0] ChPercent = 8'h25;
  localparam logic [7:0] ChPlus    = 8'h2B;
  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [3:0] HexLetterBase = 4'd10;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2,
    PH_DONE  = 2'd3
  } phase_e;

  // one decoded result word
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } res_t;

  // decoder outcome for one input word
  typedef struct packed {
    logic [1:0] count;   // 0..2 results
    res_t       r0;
    res_t       r1;
    phase_e     phase;
    logic [7:0] held;
  } dec_t;

  function automatic logic is_hex(input logic [7:0] b);
    return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h46) ||
           (b >= 8'h61 && b <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] b);
    logic [3:0] v;
    v = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) v = b[3:0];
    else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
      v = b[3:0] - 4'd1 + HexLetterBase;
    return v;
  endfunction

endpackage

`default_nettype wire

// File: hdl/upd_decode.sv
// ----------------------------------------------------------------------------
// upd_decode
// Combinational decode of one encoded byte against the current phase.
// ----------------------------------------------------------------------------
`default_nettype none

module upd_decode (
  input  wire logic [7:0]      byte_i,
  input  wire logic            last_i,
  input  wire upd_pkg::phase_e phase_i,
  input  wire logic [7:0]      held_i,
  output upd_pkg::dec_t        dec_o
);
  import upd_pkg::*;

  res_t       res [2];
  logic [1:0] n;
  phase_e     nph;
  logic [7:0] nheld;
  logic [7:0] plain_b;

  assign plain_b = (byte_i == ChPlus) ? ChSpace : byte_i;

  always_comb begin
    n      = 2'd0;
    res[0] = '0;
    res[1] = '0;
    nph    = phase_i;
    nheld  = held_i;

    if (phase_i == PH_DONE) begin
      // string already ended, swallow
    end else if (byte_i == ChNul) begin
      if (phase_i == PH_DIGIT) begin
        res[n[0]] = '{data: held_i, has: 1'b1, last: 1'b0};
        n = n + 2'd1;
      end
      nph   = PH_DONE;
      nheld = 8'd0;
    end else if (phase_i == PH_PCT && is_hex(byte_i)) begin
      nheld = byte_i;
      nph   = PH_DIGIT;
    end else if (phase_i == PH_DIGIT && is_hex(byte_i)) begin
      res[n[0]] = '{data: {hex_val(held_i), hex_val(byte_i)}, has: 1'b1, last: 1'b0};
      n     = n + 2'd1;
      nph   = PH_IDLE;
      nheld = 8'd0;
    end else begin
      // held digit without a second one goes out as itself
      if (phase_i == PH_DIGIT) begin
        res[n[0]] = '{data: held_i, has: 1'b1, last: 1'b0};
        n     = n + 2'd1;
        nheld = 8'd0;
      end
      if (byte_i == ChPercent) begin
        nph = PH_PCT;
      end else begin
        nph = PH_IDLE;
        res[n[0]] = '{data: plain_b, has: 1'b1, last: 1'b0};
        n = n + 2'd1;
      end
    end

    if (last_i) begin
      if (nph == PH_DIGIT) begin
        res[n[0]] = '{data: nheld, has: 1'b1, last: 1'b0};
        n = n + 2'd1;
      end
      if (n == 2'd0) begin
        res[0] = '{data: 8'd0, has: 1'b0, last: 1'b0};
        n = 2'd1;
      end
      if (n == 2'd1) res[0].last = 1'b1;
      else           res[1].last = 1'b1;
      nph   = PH_IDLE;
      nheld = 8'd0;
    end

    dec_o.count = n;
    dec_o.r0    = res[0];
    dec_o.r1    = res[1];
    dec_o.phase = nph;
    dec_o.held  = nheld;
  end

endmodule

`default_nettype wire

// File: hdl/url_percent_decoder_top.sv
// ----------------------------------------------------------------------------
// url_percent_decoder_top
// Streaming URL percent decoder: encoded bytes in, decoded bytes out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one encoded byte per word
//   with in_last_i on the final byte of a string. Output channel
//   (out_valid_o / out_stall_i) carries decoded words: out_byte_o, has_byte_o
//   (0 on an empty end marker) and out_last_o on the final word of a string.
//   A word moves when valid is high and stall is low.
// Path: an accepted byte lands in the input register, is decoded from there
//   into a 4-word result queue once the queue has room for two words, and
//   is offered on the output from the queue head.
// Throughput: one byte per cycle while the queue has room. An input byte
//   yields up to two results; the output port drains one word per cycle,
//   so a byte that gives two results is drained as two output words. The
//   decode step fires only when the queue has room for two words, which
//   bounds the input rate to the output drain rate.
// Reset: rst_ni (async, active low) empties the input register and the
//   queue and returns the decoder to idle with no percent pending.
// Stall: with out_stall_i high the queue head holds; once the queue lacks
//   room for two words the decode step waits and in_stall_o rises. Neither
//   valid output looks at the opposite stall combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module url_percent_decoder_top #(
  parameter int unsigned QDepth = 4   // result queue depth, power of two, >= 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output      logic       in_stall_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output      logic       out_valid_o,
  input  wire logic       out_stall_i,
  output      logic [7:0] out_byte_o,
  output      logic       has_byte_o,
  output      logic       out_last_o
);
  import upd_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = PtrW + 1;
  localparam logic [CntW-1:0] Depth   = CntW'(QDepth);
  localparam logic [CntW-1:0] RoomFor2 = CntW'(QDepth - 2);

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // decoder state
  phase_e     phase_q;
  logic [7:0] held_q;

  // result queue
  res_t            mem_q [QDepth];
  logic [PtrW-1:0] wp_q, rp_q;
  logic [CntW-1:0] cnt_q, cnt_d;

  dec_t dec;
  logic fire, push_in, pop;

  upd_decode u_dec (
    .byte_i  (in_byte_q),
    .last_i  (in_last_q),
    .phase_i (phase_q),
    .held_i  (held_q),
    .dec_o   (dec)
  );

  // decode only when two words surely fit
  assign fire    = in_vld_q && (cnt_q <= RoomFor2);
  assign push_in = in_valid_i && !in_stall_o;
  assign pop     = out_valid_o && !out_stall_i;

  assign in_stall_o  = in_vld_q && !fire;
  assign out_valid_o = (cnt_q != '0);
  assign out_byte_o  = mem_q[rp_q].data;
  assign has_byte_o  = mem_q[rp_q].has;
  assign out_last_o  = mem_q[rp_q].last;

  always_comb begin
    cnt_d = cnt_q;
    if (fire) cnt_d = cnt_d + CntW'(dec.count);
    if (pop)  cnt_d = cnt_d - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      phase_q  <= PH_IDLE;
      held_q   <= 8'd0;
      wp_q     <= '0;
      rp_q     <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_in)   in_vld_q <= 1'b1;
      else if (fire) in_vld_q <= 1'b0;
      if (fire) begin
        phase_q <= dec.phase;
        held_q  <= dec.held;
        wp_q    <= wp_q + PtrW'(dec.count);
      end
      if (pop) rp_q <= rp_q + PtrW'(1);
      cnt_q <= cnt_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (push_in) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
    if (fire) begin
      if (dec.count != 2'd0) mem_q[wp_q] <= dec.r0;
      if (dec.count == 2'd2) mem_q[wp_q + PtrW'(1)] <= dec.r1;
    end
  end

  // ---------------------------------------------------------------- checks
  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Depth)
    else $error("result queue overfilled");

  a_last_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_last_q |=> phase_q == PH_IDLE && held_q == 8'd0)
    else $error("decoder not idle after end of string");

  a_last_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && in_last_q |=> cnt_q != '0)
    else $error("end of string produced no result");

  a_held_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PH_DIGIT |-> held_q == 8'd0)
    else $error("held digit set outside digit phase");

endmodule

`default_nettype wire
